// ----- hdl/jtl_pkg.sv -----
`default_nettype none
package jtl_pkg;

    localparam int MAX_TEXT_BYTES_DEF = 65536;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int MAX_TOKENS = 4;

    localparam logic [3:0] TOK_SPACE   = 4'd0;
    localparam logic [3:0] TOK_KEY     = 4'd1;
    localparam logic [3:0] TOK_STRING  = 4'd2;
    localparam logic [3:0] TOK_NUMBER  = 4'd3;
    localparam logic [3:0] TOK_BOOLEAN = 4'd4;
    localparam logic [3:0] TOK_NULL    = 4'd5;
    localparam logic [3:0] TOK_BRACE   = 4'd6;
    localparam logic [3:0] TOK_BRACKET = 4'd7;
    localparam logic [3:0] TOK_COMMA   = 4'd8;
    localparam logic [3:0] TOK_COLON   = 4'd9;
    localparam logic [3:0] TOK_END     = 4'd10;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COLON = 8'h3a;

    typedef struct packed {
        logic [15:0] token_index;
        logic [7:0]  first_char;
        logic [16:0] token_length;
        logic [15:0] token_offset;
        logic [3:0]  token_type;
    } token_t;

    typedef struct packed {
        logic [2:0]                 cnt;
        token_t [MAX_TOKENS-1:0]    tok;
    } batch_t;

    function automatic token_t mk_tok(input logic [3:0] t, input logic [15:0] s,
                                      input logic [16:0] l, input logic [7:0] f);
        token_t r;
        r.token_type   = t;
        r.token_offset = s;
        r.token_length = l;
        r.first_char   = f;
        r.token_index  = 16'd0;
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/jtl_front.sv -----
`default_nettype none
module jtl_front #(
    parameter int MAX_TEXT_BYTES = jtl_pkg::MAX_TEXT_BYTES_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           acc,
    input  wire logic [7:0]     text_byte,
    input  wire logic           final_byte,
    output jtl_pkg::batch_t     batch,
    output logic                push
);
    import jtl_pkg::*;

    localparam int POS_W = $clog2(MAX_TEXT_BYTES + 1);
    localparam int START_CAP = (MAX_TEXT_BYTES - 1 > 65535) ? 65535 : MAX_TEXT_BYTES - 1;
    localparam int LEN_CAP = (MAX_TEXT_BYTES > 131071) ? 131071 : MAX_TEXT_BYTES;

    localparam logic [2:0] M_IDLE = 3'd0;
    localparam logic [2:0] M_WS   = 3'd1;
    localparam logic [2:0] M_STR  = 3'd2;
    localparam logic [2:0] M_NUM  = 3'd3;
    localparam logic [2:0] M_KW   = 3'd4;

    logic [2:0]       mode_reg, mode_next;
    logic             esc_reg, esc_next;
    logic [1:0]       kind_reg, kind_next;
    logic [2:0]       prog_reg, prog_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      ostart_reg, ostart_next;
    logic [POS_W-1:0] olen_reg, olen_next;
    logic [7:0]       ofirst_reg, ofirst_next;
    logic             held_reg, held_next;
    logic [15:0]      hstart_reg, hstart_next;
    logic [POS_W-1:0] hlen_reg, hlen_next;
    logic [15:0]      count_reg, count_next;

    token_t [MAX_TOKENS-1:0] slot;
    logic [2:0]       n;
    logic             fresh;
    logic [15:0]      cur;
    logic [1:0]       k;
    logic [7:0]       b;
    logic             ws, dig, numc;

    function automatic logic [16:0] clen(input logic [POS_W-1:0] v);
        return (32'(v) > LEN_CAP) ? 17'(LEN_CAP) : 17'(v);
    endfunction

    function automatic logic [15:0] cstart(input logic [POS_W-1:0] v);
        return (32'(v) > START_CAP) ? 16'(START_CAP) : 16'(v);
    endfunction

    function automatic logic [POS_W-1:0] linc(input logic [POS_W-1:0] v);
        return (32'(v) < MAX_TEXT_BYTES) ? v + 1'b1 : v;
    endfunction

    function automatic logic [15:0] sat16(input logic [15:0] c, input logic [2:0] i);
        logic [16:0] s;
        s = {1'b0, c} + 17'(i);
        return s[16] ? 16'hffff : s[15:0];
    endfunction

    function automatic logic [7:0] kw_char(input logic [1:0] kk, input logic [2:0] p);
        logic [7:0] c;
        c = 8'h00;
        case (kk)
            2'd1:
            begin
                case (p)
                    3'd0: c = "f";
                    3'd1: c = "a";
                    3'd2: c = "l";
                    3'd3: c = "s";
                    3'd4: c = "e";
                    default: c = 8'h00;
                endcase
            end
            2'd2:
            begin
                case (p)
                    3'd0: c = "n";
                    3'd1: c = "u";
                    3'd2: c = "l";
                    3'd3: c = "l";
                    default: c = 8'h00;
                endcase
            end
            default:
            begin
                case (p)
                    3'd0: c = "t";
                    3'd1: c = "r";
                    3'd2: c = "u";
                    3'd3: c = "e";
                    default: c = 8'h00;
                endcase
            end
        endcase
        return c;
    endfunction

    always_comb
    begin
        b = text_byte;
        ws = (b == " ") || (b == 8'h09) || (b == 8'h0a) || (b == 8'h0d);
        dig = (b >= "0") && (b <= "9");
        numc = dig || (b == ".") || (b == "e") || (b == "E") || (b == "+") || (b == "-");
        cur = cstart(pos_reg);
        k = (kind_reg == 2'd3) ? 2'd0 : kind_reg;

        mode_next = mode_reg;
        esc_next = esc_reg;
        kind_next = kind_reg;
        prog_next = prog_reg;
        ostart_next = ostart_reg;
        olen_next = olen_reg;
        ofirst_next = ofirst_reg;
        held_next = held_reg;
        hstart_next = hstart_reg;
        hlen_next = hlen_reg;
        slot = '0;
        n = 3'd0;
        fresh = 1'b0;

        case (mode_reg)
            M_STR:
            begin
                olen_next = linc(olen_reg);
                if (esc_reg)
                    esc_next = 1'b0;
                else if (b == 8'h5c)
                    esc_next = 1'b1;
                else if (b == CH_QUOTE)
                begin
                    held_next = 1'b1;
                    hstart_next = ostart_reg;
                    hlen_next = olen_next;
                    mode_next = M_IDLE;
                end
            end
            M_NUM:
            begin
                if (numc)
                    olen_next = linc(olen_reg);
                else
                begin
                    slot[n[1:0]] = mk_tok(TOK_NUMBER, ostart_reg, clen(olen_reg), ofirst_reg);
                    n = n + 3'd1;
                    mode_next = M_IDLE;
                    fresh = 1'b1;
                end
            end
            M_KW:
            begin
                if ((prog_reg < ((k == 2'd1) ? 3'd5 : 3'd4)) && (b == kw_char(k, prog_reg)))
                begin
                    prog_next = prog_reg + 3'd1;
                    if (prog_next >= ((k == 2'd1) ? 3'd5 : 3'd4))
                    begin
                        slot[n[1:0]] = mk_tok((k == 2'd2) ? TOK_NULL : TOK_BOOLEAN, ostart_reg,
                                              (k == 2'd1) ? 17'd5 : 17'd4, kw_char(k, 3'd0));
                        n = n + 3'd1;
                        mode_next = M_IDLE;
                    end
                end
                else
                begin
                    mode_next = M_IDLE;
                    fresh = 1'b1;
                end
            end
            default:
                fresh = 1'b1;
        endcase

        if (fresh)
        begin
            if (held_next && (b != " ") && (b != 8'h09))
            begin
                slot[n[1:0]] = mk_tok((b == CH_COLON) ? TOK_KEY : TOK_STRING, hstart_next,
                                      clen(hlen_next), CH_QUOTE);
                n = n + 3'd1;
                held_next = 1'b0;
            end
            if ((mode_next == M_WS) && ws)
                olen_next = linc(olen_reg);
            else
            begin
                if (mode_next == M_WS)
                begin
                    slot[n[1:0]] = mk_tok(TOK_SPACE, ostart_reg, clen(olen_reg), ofirst_reg);
                    n = n + 3'd1;
                end
                mode_next = M_IDLE;
                ostart_next = cur;
                olen_next = POS_W'(1);
                ofirst_next = b;
                if (ws)
                    mode_next = M_WS;
                else if (b == CH_QUOTE)
                begin
                    mode_next = M_STR;
                    esc_next = 1'b0;
                end
                else if (dig || (b == "+") || (b == "-"))
                    mode_next = M_NUM;
                else if ((b == "t") || (b == "f") || (b == "n"))
                begin
                    mode_next = M_KW;
                    kind_next = (b == "t") ? 2'd0 : ((b == "f") ? 2'd1 : 2'd2);
                    prog_next = 3'd1;
                end
                else if ((b == "{") || (b == "}") || (b == "[") || (b == "]") || (b == ",")
                         || (b == CH_COLON))
                begin
                    slot[n[1:0]] = mk_tok(((b == "{") || (b == "}")) ? TOK_BRACE :
                                          ((b == "[") || (b == "]")) ? TOK_BRACKET :
                                          (b == ",") ? TOK_COMMA : TOK_COLON,
                                          cur, 17'd1, b);
                    n = n + 3'd1;
                end
            end
        end

        pos_next = (32'(pos_reg) < MAX_TEXT_BYTES) ? pos_reg + 1'b1 : pos_reg;

        if (final_byte)
        begin
            if (held_next)
            begin
                slot[n[1:0]] = mk_tok(TOK_STRING, hstart_next, clen(hlen_next), CH_QUOTE);
                n = n + 3'd1;
            end
            if (mode_next == M_WS)
            begin
                slot[n[1:0]] = mk_tok(TOK_SPACE, ostart_next, clen(olen_next), ofirst_next);
                n = n + 3'd1;
            end
            else if (mode_next == M_NUM)
            begin
                slot[n[1:0]] = mk_tok(TOK_NUMBER, ostart_next, clen(olen_next), ofirst_next);
                n = n + 3'd1;
            end
            else if (mode_next == M_STR)
            begin
                slot[n[1:0]] = mk_tok(TOK_STRING, ostart_next, clen(olen_next), CH_QUOTE);
                n = n + 3'd1;
            end
            for (int i = 0; i < MAX_TOKENS; i++)
                if (3'(i) < n)
                    slot[i].token_index = sat16(count_reg, 3'(i));
            slot[n[1:0]] = mk_tok(TOK_END, cstart(pos_next), 17'd0, 8'h00);
            slot[n[1:0]].token_index = sat16(count_reg, n);
            n = n + 3'd1;
            mode_next = M_IDLE;
            esc_next = 1'b0;
            kind_next = 2'd0;
            prog_next = 3'd0;
            pos_next = '0;
            ostart_next = 16'd0;
            olen_next = '0;
            ofirst_next = 8'h00;
            held_next = 1'b0;
            hstart_next = 16'd0;
            hlen_next = '0;
            count_next = 16'd0;
        end
        else
        begin
            for (int i = 0; i < MAX_TOKENS; i++)
                slot[i].token_index = sat16(count_reg, 3'(i));
            count_next = sat16(count_reg, n);
        end

        batch.cnt = n;
        batch.tok = slot;
        push = acc && (n != 3'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            esc_reg <= 1'b0;
            kind_reg <= 2'd0;
            prog_reg <= 3'd0;
            pos_reg <= '0;
            ostart_reg <= 16'd0;
            olen_reg <= '0;
            ofirst_reg <= 8'h00;
            held_reg <= 1'b0;
            hstart_reg <= 16'd0;
            hlen_reg <= '0;
            count_reg <= 16'd0;
        end
        else if (acc)
        begin
            mode_reg <= mode_next;
            esc_reg <= esc_next;
            kind_reg <= kind_next;
            prog_reg <= prog_next;
            pos_reg <= pos_next;
            ostart_reg <= ostart_next;
            olen_reg <= olen_next;
            ofirst_reg <= ofirst_next;
            held_reg <= held_next;
            hstart_reg <= hstart_next;
            hlen_reg <= hlen_next;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/jtl_queue.sv -----
`default_nettype none
module jtl_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  jtl_pkg::batch_t     wr_data,
    output logic                has_room,
    input  wire logic           pop,
    output logic                not_empty,
    output jtl_pkg::batch_t     rd_data
);
    import jtl_pkg::*;

    batch_t           mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [QPTR_W:0]   cnt_reg;

    assign has_room = cnt_reg < (QPTR_W+1)'(QUEUE_DEPTH);
    assign not_empty = cnt_reg != '0;
    assign rd_data = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/jtl_back.sv -----
`default_nettype none
module jtl_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           not_empty,
    input  jtl_pkg::batch_t     rd_data,
    output logic                pop,
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    output logic [63:0]         m_axis_tdata,
    output logic                m_axis_tlast
);
    import jtl_pkg::*;

    logic [1:0]  sub_reg;
    logic        vld_reg;
    token_t      tok_reg;
    logic        last_reg;
    logic        load;
    logic        end_of_batch;

    assign load = not_empty && (!vld_reg || m_axis_tready);
    assign end_of_batch = ({1'b0, sub_reg} + 3'd1) == rd_data.cnt;
    assign pop = load && end_of_batch;

    assign m_axis_tvalid = vld_reg;
    assign m_axis_tdata = {3'b000, tok_reg};
    assign m_axis_tlast = last_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tok_reg <= rd_data.tok[sub_reg];
            last_reg <= end_of_batch;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg <= 2'd0;
            vld_reg <= 1'b0;
        end
        else
        begin
            if (load)
                sub_reg <= end_of_batch ? 2'd0 : sub_reg + 2'd1;
            if (load)
                vld_reg <= 1'b1;
            else if (m_axis_tready)
                vld_reg <= 1'b0;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/json_token_lexer_top.sv -----
// JSON token lexer.
// Input stream: one text byte per transaction, s_axis_tdata[7:0] = text_byte,
// s_axis_tlast = final_byte (last byte of the text).
// Output stream: one token per transaction, m_axis_tlast = run_last, set on
// the last token caused by an input byte.
// Bytes are taken one per cycle whenever the token queue has room; the byte
// state is registered in the front end on each taken byte, and the front end
// packs the 0..4 tokens a byte yields into one queue entry.
// The back end drains one token per cycle while the receiver is ready, into
// a registered output; each token passes the queue and then that register.
// A byte's tokens go out in turn; the 4-entry queue absorbs these bursts.
// Strings stay held until the next byte other than space or tab decides
// key or string. The final byte flushes open string, number and blank
// tokens, adds an end token and resets the lexer state for the next text.
// Reset clears all lexer state and the queue. A stalled receiver fills the
// queue, after which s_axis_tready drops until space frees up.
`default_nettype none
module json_token_lexer_top #(
    parameter int MAX_TEXT_BYTES = jtl_pkg::MAX_TEXT_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [3:0] token_type, [19:4] token_offset, [36:20] token_length,
    // [44:37] first_char, [60:45] token_index, [63:61] zero
    output logic [63:0]      m_axis_tdata,
    output logic             m_axis_tlast
);
    import jtl_pkg::*;

    batch_t wr_batch, rd_batch;
    logic   push, pop, has_room, not_empty, acc;

    assign s_axis_tready = has_room;
    assign acc = s_axis_tvalid && has_room;

    jtl_front #(.MAX_TEXT_BYTES(MAX_TEXT_BYTES)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .acc        (acc),
        .text_byte  (s_axis_tdata),
        .final_byte (s_axis_tlast),
        .batch      (wr_batch),
        .push       (push)
    );

    jtl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_data   (wr_batch),
        .has_room  (has_room),
        .pop       (pop),
        .not_empty (not_empty),
        .rd_data   (rd_batch)
    );

    jtl_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .not_empty     (not_empty),
        .rd_data       (rd_batch),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
`default_nettype wire

// ----- hdl/jtl_checker.sv -----
`default_nettype none
module jtl_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);
    import jtl_pkg::*;

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[3:0] == TOK_END) |->
            m_axis_tlast && (m_axis_tdata[36:20] == 17'd0) && (m_axis_tdata[44:37] == 8'h00))
        else $error("malformed end token");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && ((m_axis_tdata[3:0] == TOK_KEY) || (m_axis_tdata[3:0] == TOK_STRING))
            |-> m_axis_tdata[44:37] == CH_QUOTE)
        else $error("string token without quote");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && ((m_axis_tdata[3:0] == TOK_BRACE) || (m_axis_tdata[3:0] == TOK_COMMA)
            || (m_axis_tdata[3:0] == TOK_BRACKET) || (m_axis_tdata[3:0] == TOK_COLON))
            |-> m_axis_tdata[36:20] == 17'd1)
        else $error("punctuation token length not one");

endmodule

bind json_token_lexer_top jtl_checker u_jtl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

// ----- sim/tb_json_token_lexer_top.sv -----
`timescale 1ns / 1ps
module tb_json_token_lexer_top;
    import jtl_pkg::*;

    typedef enum logic [2:0] {LX_IDLE, LX_WS, LX_STR, LX_NUM, LX_KW} lex_mode_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] start;
        logic [16:0] length;
        logic [7:0]  first;
        logic [15:0] index;
        logic        last;
    } token_rec_t;

    localparam int WATCHDOG_LIMIT = 5000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tlast;

    json_token_lexer_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // lexer shadow state
    lex_mode_t   mode;
    logic        esc;
    logic [1:0]  kw_sel;
    logic [2:0]  kw_pos;
    logic [16:0] pos;
    logic [15:0] tok_start;
    logic [16:0] tok_len;
    logic [7:0]  tok_first;
    logic        held_vld;
    logic [15:0] held_start;
    logic [16:0] held_len;
    logic [15:0] tok_count;

    token_rec_t  expected_tokens[$];
    token_rec_t  step_tokens[$];
    int          mismatches;
    int          timed_out;
    int          idle_pct;
    int          stall_pct;
    int          quiet_cycles;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic is_blank(logic [7:0] b);
        return b == " " || b == 8'h09 || b == 8'h0a || b == 8'h0d;
    endfunction

    function automatic logic is_num_char(logic [7:0] b);
        return (b >= "0" && b <= "9") || b == "." || b == "e" || b == "E" ||
               b == "+" || b == "-";
    endfunction

    function automatic logic [7:0] kw_char(logic [1:0] k, logic [2:0] i);
        string s;
        s = (k == 2'd0) ? "true" : (k == 2'd1) ? "false" : "null";
        return (i < s.len()) ? s[i] : 8'h00;
    endfunction

    function automatic logic [16:0] len_sat(logic [16:0] v);
        return (v < 17'd65536) ? v + 17'd1 : v;
    endfunction

    task automatic add_token(logic [3:0] k, logic [15:0] s, logic [16:0] l, logic [7:0] f);
        token_rec_t t;
        t.kind   = k;
        t.start  = s;
        t.length = l;
        t.first  = f;
        t.index  = tok_count;
        t.last   = 1'b0;
        if (k != TOK_END && tok_count != 16'hffff)
            tok_count = tok_count + 16'd1;
        step_tokens.push_back(t);
    endtask

    task automatic clear_lexer();
        mode = LX_IDLE; esc = 1'b0; kw_sel = '0; kw_pos = '0; pos = '0;
        tok_start = '0; tok_len = '0; tok_first = '0;
        held_vld = 1'b0; held_start = '0; held_len = '0; tok_count = '0;
    endtask

    task automatic lex_fresh(logic [7:0] b, logic [15:0] cur);
        if (held_vld && b != " " && b != 8'h09)
        begin
            add_token(b == CH_COLON ? TOK_KEY : TOK_STRING, held_start, held_len, CH_QUOTE);
            held_vld = 1'b0;
        end
        if (mode == LX_WS)
        begin
            if (is_blank(b))
            begin
                tok_len = len_sat(tok_len);
                return;
            end
            add_token(TOK_SPACE, tok_start, tok_len, tok_first);
        end
        mode = LX_IDLE;
        tok_start = cur;
        tok_len = 17'd1;
        tok_first = b;
        if (is_blank(b))
            mode = LX_WS;
        else if (b == CH_QUOTE)
        begin
            mode = LX_STR;
            esc = 1'b0;
        end
        else if ((b >= "0" && b <= "9") || b == "+" || b == "-")
            mode = LX_NUM;
        else if (b == "t" || b == "f" || b == "n")
        begin
            mode = LX_KW;
            kw_sel = (b == "t") ? 2'd0 : (b == "f") ? 2'd1 : 2'd2;
            kw_pos = 3'd1;
        end
        else if (b == "{" || b == "}")
            add_token(TOK_BRACE, cur, 17'd1, b);
        else if (b == "[" || b == "]")
            add_token(TOK_BRACKET, cur, 17'd1, b);
        else if (b == ",")
            add_token(TOK_COMMA, cur, 17'd1, b);
        else if (b == CH_COLON)
            add_token(TOK_COLON, cur, 17'd1, b);
    endtask

    task automatic lex_byte(logic [7:0] b, logic fin);
        logic [15:0] cur;
        logic [2:0]  kw_n;
        token_rec_t  t;
        cur = (pos > 17'd65535) ? 16'hffff : pos[15:0];
        kw_n = (kw_sel == 2'd1) ? 3'd5 : 3'd4;
        step_tokens.delete();
        case (mode)
            LX_STR:
            begin
                tok_len = len_sat(tok_len);
                if (esc)
                    esc = 1'b0;
                else if (b == "\\")
                    esc = 1'b1;
                else if (b == CH_QUOTE)
                begin
                    held_vld = 1'b1; held_start = tok_start; held_len = tok_len;
                    mode = LX_IDLE;
                end
            end
            LX_NUM:
            begin
                if (is_num_char(b))
                    tok_len = len_sat(tok_len);
                else
                begin
                    add_token(TOK_NUMBER, tok_start, tok_len, tok_first);
                    mode = LX_IDLE;
                    lex_fresh(b, cur);
                end
            end
            LX_KW:
            begin
                if (kw_pos < kw_n && b == kw_char(kw_sel, kw_pos))
                begin
                    kw_pos = kw_pos + 3'd1;
                    if (kw_pos >= kw_n)
                    begin
                        add_token(kw_sel == 2'd2 ? TOK_NULL : TOK_BOOLEAN, tok_start,
                                  17'(kw_n), kw_char(kw_sel, 3'd0));
                        mode = LX_IDLE;
                    end
                end
                else
                begin
                    mode = LX_IDLE;
                    lex_fresh(b, cur);
                end
            end
            default: lex_fresh(b, cur);
        endcase
        if (pos < 17'd65536)
            pos = pos + 17'd1;
        if (fin)
        begin
            if (held_vld)
                add_token(TOK_STRING, held_start, held_len, CH_QUOTE);
            if (mode == LX_WS)
                add_token(TOK_SPACE, tok_start, tok_len, tok_first);
            else if (mode == LX_NUM)
                add_token(TOK_NUMBER, tok_start, tok_len, tok_first);
            else if (mode == LX_STR)
                add_token(TOK_STRING, tok_start, tok_len, CH_QUOTE);
            add_token(TOK_END, (pos > 17'd65535) ? 16'hffff : pos[15:0], 17'd0, 8'h00);
            clear_lexer();
        end
        for (int i = 0; i < step_tokens.size(); i++)
        begin
            t = step_tokens[i];
            t.last = (i == step_tokens.size() - 1);
            expected_tokens.push_back(t);
        end
    endtask

    task automatic send_byte(logic [7:0] b, logic fin);
        while (($urandom % 100) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        lex_byte(b, fin);
    endtask

    task automatic send_text(string txt, logic fin);
        for (int i = 0; i < txt.len(); i++)
            send_byte(txt[i], fin && i == txt.len() - 1);
    endtask

    // output side
    always @(posedge clk)
    begin
        if (rst_n)
            m_axis_tready <= (($urandom % 100) >= stall_pct);
    end

    always @(posedge clk)
    begin
        token_rec_t e;
        token_rec_t a;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            a = {m_axis_tdata[3:0], m_axis_tdata[19:4], m_axis_tdata[36:20],
                 m_axis_tdata[44:37], m_axis_tdata[60:45], m_axis_tlast};
            if (expected_tokens.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected token: %h", a);
            end
            else
            begin
                e = expected_tokens.pop_front();
                if (a !== e || m_axis_tdata[63:61] !== 3'b000)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"token mismatch: exp %0d %0d %0d %h %0d %0b",
                                  " / got %0d %0d %0d %h %0d %0b"},
                                 e.kind, e.start, e.length, e.first, e.index, e.last,
                                 a.kind, a.start, a.length, a.first, a.index, a.last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic test_directed();
        send_text("{\"key\" \t: \"v\\\"a\\\\l\" , \"s\"]", 1'b0);
        send_text("[-12.5e+3,true false null]", 1'b0);
        send_text("tru3 fals nx \x80\xff\x01 \r\n:", 1'b0);
        send_text(" 42", 1'b1);
        send_text("\"open", 1'b1);
        send_text("\"a\"  ", 1'b1);
        send_text("nul", 1'b1);
        send_byte(8'hff, 1'b1);
    endtask

    function automatic string random_piece();
        case ($urandom_range(0, 13))
            0: return "\"ab\\\"c\"";
            1: return "\"k\" :";
            2: return "\"k\"\t:";
            3: return "-3.1e5";
            4: return "true";
            5: return "false";
            6: return "null";
            7: return " \t\n\r";
            8: return "{";
            9: return "}";
            10: return "[]";
            11: return ",";
            12: return "fa1";
            default: return ":";
        endcase
    endfunction

    task automatic test_random_text(int n_bytes);
        string s;
        int    sent;
        sent = 0;
        while (sent < n_bytes)
        begin
            if ($urandom_range(0, 9) < 8)
                s = random_piece();
            else
            begin
                s = " ";
                s[0] = 8'($urandom_range(1, 255));
            end
            send_text(s, $urandom_range(0, 29) == 0);
            sent += s.len();
        end
    endtask

    task automatic test_no_idle(int n_bytes);
        idle_pct = 0;
        stall_pct = 0;
        test_random_text(n_bytes);
        idle_pct = 29;
        stall_pct = 29;
    endtask

    task automatic test_long_token();
        send_byte("1", 1'b0);
        for (int i = 0; i < 40; i++)
            send_byte("0", 1'b0);
        send_byte(" ", 1'b1);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'h00;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        mismatches = 0;
        quiet_cycles = 0;
        idle_pct = 29;
        stall_pct = 29;
        clear_lexer();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_text(200);
        test_no_idle(110);
        test_long_token();
        test_random_text(20);
        send_byte("}", 1'b1);
        s_axis_tvalid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_tokens.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
